// ----- rtl/core/lpm_pkg.sv -----
package lpm_pkg;

    // Table geometry.
    localparam int MAX_PREFIXES = 128;
    localparam int MAX_LEN      = 20;

    // Field widths fixed by the interface.
    localparam int SLOT_W  = 7;
    localparam int POS_W   = 5;
    localparam int CHAR_W  = 8;
    localparam int CNT_W   = 8;
    localparam int MLEN_W  = 5;

    // A stored length is char_pos + 1, so it needs one bit more than a position.
    localparam int LEN_W   = POS_W + 1;

    // Address width of the per-position character memory.
    localparam int CHAR_AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;

    // Selection tree: slots are reduced in groups, then the group winners.
    localparam int GROUP_SIZE = 16;
    localparam int GROUPS     = (MAX_PREFIXES + GROUP_SIZE - 1) / GROUP_SIZE;
    localparam int GROUPS_P2  = 1 << ((GROUPS > 1) ? $clog2(GROUPS) : 0);

    // Command kinds.
    localparam logic KIND_LOAD  = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    // Register index (taken from paddr[2]).
    localparam logic REG_PREFIX_COUNT = 1'b0;

    typedef struct packed {
        logic              kind;
        logic [SLOT_W-1:0] slot;
        logic [POS_W-1:0]  char_pos;
        logic [CHAR_W-1:0] char_value;
        logic              last_char;
    } cmd_t;

    typedef struct packed {
        logic              found;
        logic [SLOT_W-1:0] prefix_index;
        logic [MLEN_W-1:0] match_length;
    } result_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [SLOT_W-1:0] idx;
    } cand_t;

    typedef struct packed {
        logic             group_en;
        logic             final_en;
        logic [LEN_W-1:0] word_len;
        logic [CNT_W-1:0] active_count;
    } sel_ctrl_t;

    // The right candidate wins only when strictly longer, so ties keep the lower slot.
    function automatic cand_t cand_merge(input cand_t left, input cand_t right);
        cand_t res;
        res = (right.len > left.len) ? right : left;
        return res;
    endfunction

endpackage

// ----- rtl/core/lpm_char_mem.sv -----
module lpm_char_mem
    import lpm_pkg::*;
(
    input  logic                                 clk,
    input  logic                                 wr_en,
    input  logic [CHAR_AW-1:0]                   wr_addr,
    input  logic [SLOT_W-1:0]                    wr_slot,
    input  logic [CHAR_W-1:0]                    wr_data,
    input  logic                                 rd_en,
    input  logic [CHAR_AW-1:0]                   rd_addr,
    output logic [MAX_PREFIXES-1:0][CHAR_W-1:0]  rd_data
);

    // One row per character position, holding that position of every slot.
    logic [MAX_PREFIXES-1:0][CHAR_W-1:0] mem [MAX_LEN];
    logic [MAX_PREFIXES-1:0][CHAR_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr][wr_slot] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- rtl/core/lpm_select.sv -----
module lpm_select
    import lpm_pkg::*;
(
    input  logic                    clk,
    input  sel_ctrl_t               ctrl,
    input  logic [LEN_W-1:0]        lengths [MAX_PREFIXES],
    input  logic [MAX_PREFIXES-1:0] match_flags,
    output result_t                 best
);

    cand_t   gnode [GROUPS][2*GROUP_SIZE];
    cand_t   group_best_reg [GROUPS];
    cand_t   fnode [2*GROUPS_P2];
    result_t best_reg;

    // First level: the best eligible slot of each group, as a binary tree.
    always_comb
    begin
        for (int g = 0; g < GROUPS; g++)
        begin
            for (int n = 0; n < 2*GROUP_SIZE; n++)
            begin
                gnode[g][n] = '0;
            end
            for (int i = 0; i < GROUP_SIZE; i++)
            begin
                if ((g*GROUP_SIZE + i) < MAX_PREFIXES)
                begin
                    if (((g*GROUP_SIZE + i) < int'(ctrl.active_count))
                        && (lengths[g*GROUP_SIZE + i] != '0)
                        && (lengths[g*GROUP_SIZE + i] <= ctrl.word_len)
                        && match_flags[g*GROUP_SIZE + i])
                    begin
                        gnode[g][GROUP_SIZE + i].len = lengths[g*GROUP_SIZE + i];
                        gnode[g][GROUP_SIZE + i].idx = SLOT_W'(g*GROUP_SIZE + i);
                    end
                end
            end
            for (int n = GROUP_SIZE - 1; n >= 1; n--)
            begin
                gnode[g][n] = cand_merge(gnode[g][2*n], gnode[g][2*n + 1]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.group_en)
        begin
            for (int g = 0; g < GROUPS; g++)
            begin
                group_best_reg[g] <= gnode[g][1];
            end
        end
    end

    // Second level: the group winners, lower groups first.
    always_comb
    begin
        for (int n = 0; n < 2*GROUPS_P2; n++)
        begin
            fnode[n] = '0;
        end
        for (int g = 0; g < GROUPS; g++)
        begin
            fnode[GROUPS_P2 + g] = group_best_reg[g];
        end
        for (int n = GROUPS_P2 - 1; n >= 1; n--)
        begin
            fnode[n] = cand_merge(fnode[2*n], fnode[2*n + 1]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.final_en)
        begin
            best_reg.found        <= (fnode[1].len != '0);
            best_reg.prefix_index <= fnode[1].idx;
            best_reg.match_length <= fnode[1].len[MLEN_W-1:0];
        end
    end

    assign best = best_reg;

endmodule

// ----- rtl/core/longest_prefix_match_unit.sv -----
// Channel   Ports                                        Handshake
// -------   -------------------------------------------  -------------------------------
// command   cmd (kind, slot, char_pos, char_value, ...)   taken when start & !busy
// result    result (found, prefix_index, match_length)   valid for one cycle with done
// config    psel, penable, pwrite, paddr, pwdata, prdata  APB read/write, pready tied high
//
// A load word needs no extra state: the character is written into the position memory at
// the accepting edge, so busy never rises. A query word reads one position row of the
// memory at its accepting edge and then compares it against every slot in state CMP.
// After the last query word the two-level selection tree runs in SEL1 and SEL2, and its
// result appears with done in the cycle after SEL2, while busy is already low again.
// Reset clears the lengths, the prefix count and sets every match flag; the character
// memory is not cleared. The receiver cannot stall, so done is never held.
module longest_prefix_match_unit
    import lpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cmd_t        cmd,
    output logic        done,
    output result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // Sequencer states.
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_SEL1 = 2'd2;
    localparam logic [1:0] ST_SEL2 = 2'd3;

    logic [1:0]              state_reg;
    logic [1:0]              state_next;
    logic                    done_reg;
    logic [CNT_W-1:0]        prefix_count_reg;

    // Query word held for the compare cycle.
    logic [POS_W-1:0]        pos_reg;
    logic [CHAR_W-1:0]       char_reg;
    logic                    last_reg;
    logic                    in_range_reg;
    logic [LEN_W-1:0]        word_len_reg;

    logic [LEN_W-1:0]        len_reg [MAX_PREFIXES];
    logic [MAX_PREFIXES-1:0] flags_reg;
    logic [MAX_PREFIXES-1:0] flags_next;

    logic                    accept;
    logic                    load_accept;
    logic                    query_accept;
    logic                    pos_in_range;
    logic                    cfg_write;

    logic [MAX_PREFIXES-1:0][CHAR_W-1:0] row_data;
    sel_ctrl_t               sel_ctrl;
    result_t                 sel_best;

    assign accept       = start && !busy;
    assign load_accept  = accept && (cmd.kind == KIND_LOAD);
    assign query_accept = accept && (cmd.kind == KIND_QUERY);
    assign pos_in_range = int'(cmd.char_pos) < MAX_LEN;
    assign busy         = (state_reg != ST_IDLE);

    // Configuration port: a single register at index zero.
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == REG_PREFIX_COUNT);
    assign prdata    = (paddr[2] == REG_PREFIX_COUNT) ? {{(32-CNT_W){1'b0}}, prefix_count_reg}
                                                      : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prefix_count_reg <= '0;
        end
        else if (cfg_write)
        begin
            prefix_count_reg <= pwdata[CNT_W-1:0];
        end
    end

    // The memory holds one row per character position, so a query word needs one read.
    lpm_char_mem u_char_mem (
        .clk     (clk),
        .wr_en   (load_accept && pos_in_range),
        .wr_addr (cmd.char_pos[CHAR_AW-1:0]),
        .wr_slot (cmd.slot),
        .wr_data (cmd.char_value),
        .rd_en   (query_accept && pos_in_range),
        .rd_addr (cmd.char_pos[CHAR_AW-1:0]),
        .rd_data (row_data)
    );

    // Slot lengths are set by the last character of a load.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < MAX_PREFIXES; s++)
            begin
                len_reg[s] <= '0;
            end
        end
        else if (load_accept && cmd.last_char && (int'(cmd.slot) < MAX_PREFIXES))
        begin
            len_reg[cmd.slot] <= LEN_W'(cmd.char_pos) + LEN_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (query_accept)
        begin
            pos_reg      <= cmd.char_pos;
            char_reg     <= cmd.char_value;
            last_reg     <= cmd.last_char;
            in_range_reg <= pos_in_range;
            word_len_reg <= LEN_W'(cmd.char_pos) + LEN_W'(1);
        end
    end

    // Match flags: cleared slot by slot in the compare cycle, all set again once the
    // selection has taken its final snapshot.
    always_comb
    begin
        flags_next = flags_reg;
        case (state_reg)
            ST_CMP:
            begin
                if (in_range_reg)
                begin
                    for (int s = 0; s < MAX_PREFIXES; s++)
                    begin
                        if ((LEN_W'(pos_reg) < len_reg[s]) && (row_data[s] != char_reg))
                        begin
                            flags_next[s] = 1'b0;
                        end
                    end
                end
            end
            ST_SEL2:
            begin
                flags_next = '1;
            end
            default:
            begin
                flags_next = flags_reg;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query_accept)
                begin
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                state_next = last_reg ? ST_SEL1 : ST_IDLE;
            end
            ST_SEL1:
            begin
                state_next = ST_SEL2;
            end
            ST_SEL2:
            begin
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            flags_reg <= '1;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            flags_reg <= flags_next;
            done_reg  <= (state_reg == ST_SEL2);
        end
    end

    // Selection: group winners in state SEL1, the overall winner in state SEL2.
    assign sel_ctrl.group_en     = (state_reg == ST_SEL1);
    assign sel_ctrl.final_en     = (state_reg == ST_SEL2);
    assign sel_ctrl.word_len     = word_len_reg;
    assign sel_ctrl.active_count = prefix_count_reg;

    lpm_select u_select (
        .clk         (clk),
        .ctrl        (sel_ctrl),
        .lengths     (len_reg),
        .match_flags (flags_reg),
        .best        (sel_best)
    );

    assign done   = done_reg;
    assign result = sel_best;

    // A result only ever follows the final selection cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_SEL2))
        else $error("result strobe without a finished selection");

    // The last query word always yields its result, passing CMP, SEL1 and SEL2 before done.
    assert property (@(posedge clk) disable iff (!rst_n)
        (query_accept && cmd.last_char) |-> ##4 done)
        else $error("last query word produced no result");

    // No match means the index and length read as zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (done && !result.found) |-> (result.prefix_index == '0 && result.match_length == '0))
        else $error("empty result carries a slot or length");

    // Once a finished word has been through the selection, every match flag is set again.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(state_reg == ST_SEL2) |-> (flags_reg == '1))
        else $error("match flags not restored after a word");

endmodule

// ----- test/lpm_checker.sv -----
`timescale 1ns / 100ps

// Watches the command, result and register channels of the matcher, keeps its own copy
// of the prefix table and counts every result that differs from the predicted one.
module lpm_checker
    import lpm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  cmd_t        cmd,
    input  logic        done,
    input  result_t     result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic [31:0] prdata,
    input  logic        pready,
    output int          fail_count,
    output int          outstanding,
    output int          results_seen,
    output int          hits
);

    logic [CHAR_W-1:0] table_chars [MAX_PREFIXES][MAX_LEN];
    logic [LEN_W-1:0]  table_len   [MAX_PREFIXES];
    logic              match_flag  [MAX_PREFIXES];
    logic [LEN_W-1:0]  word_len;
    logic [CNT_W-1:0]  count_cfg;

    result_t due_results [$];
    int      errors;
    int      checked;
    int      hit_count;

    assign fail_count   = errors;
    assign results_seen = checked;
    assign hits         = hit_count;

    task automatic note_error(input string msg);
        if (errors < 10)
        begin
            $display("MISMATCH at %0t ns: %s", $realtime, msg);
        end
        errors++;
    endtask

    // Applies one accepted word to the table copy; a finished query yields one result.
    task automatic advance_table(input cmd_t c, output bit emits, output result_t outcome);
        int s;
        int active;
        int best_len;
        int best_idx;
        bit hit;
        emits   = 1'b0;
        outcome = '0;
        if (c.kind == KIND_LOAD)
        begin
            if (c.char_pos < MAX_LEN)
            begin
                table_chars[c.slot][c.char_pos] = c.char_value;
            end
            if (c.last_char)
            begin
                table_len[c.slot] = LEN_W'(c.char_pos) + LEN_W'(1);
            end
        end
        else
        begin
            if (c.char_pos < MAX_LEN)
            begin
                for (s = 0; s < MAX_PREFIXES; s++)
                begin
                    if (c.char_pos < table_len[s] && table_chars[s][c.char_pos] != c.char_value)
                    begin
                        match_flag[s] = 1'b0;
                    end
                end
            end
            word_len = LEN_W'(c.char_pos) + LEN_W'(1);
            if (c.last_char)
            begin
                active   = (count_cfg > MAX_PREFIXES) ? MAX_PREFIXES : count_cfg;
                best_len = 0;
                best_idx = 0;
                hit      = 1'b0;
                for (s = 0; s < active; s++)
                begin
                    if (table_len[s] != 0 && table_len[s] <= word_len && match_flag[s]
                        && table_len[s] > best_len)
                    begin
                        best_len = table_len[s];
                        best_idx = s;
                        hit      = 1'b1;
                    end
                end
                outcome.found        = hit;
                outcome.prefix_index = hit ? best_idx[SLOT_W-1:0] : '0;
                outcome.match_length = hit ? best_len[MLEN_W-1:0] : '0;
                emits = 1'b1;
                for (s = 0; s < MAX_PREFIXES; s++)
                begin
                    match_flag[s] = 1'b1;
                end
                word_len = '0;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        bit      emits;
        int      s;
        int      p;
        if (!rst_n)
        begin
            for (s = 0; s < MAX_PREFIXES; s++)
            begin
                for (p = 0; p < MAX_LEN; p++)
                begin
                    table_chars[s][p] = '0;
                end
                table_len[s]  = '0;
                match_flag[s] = 1'b1;
            end
            word_len  = '0;
            count_cfg = '0;
            due_results.delete();
            outstanding <= 0;
        end
        else
        begin
            if (start && !busy)
            begin
                advance_table(cmd, emits, want);
                if (emits)
                begin
                    due_results.push_back(want);
                end
            end
            if (done)
            begin
                checked++;
                if (result.found)
                begin
                    hit_count++;
                end
                if (due_results.size() == 0)
                begin
                    note_error($sformatf("result found=%0b index=%0d length=%0d with none due",
                                         result.found, result.prefix_index,
                                         result.match_length));
                end
                else
                begin
                    want = due_results.pop_front();
                    if (result.found !== want.found || result.prefix_index !== want.prefix_index
                        || result.match_length !== want.match_length)
                    begin
                        note_error($sformatf(
                            "expected found=%0b index=%0d length=%0d, got found=%0b index=%0d length=%0d",
                            want.found, want.prefix_index, want.match_length,
                            result.found, result.prefix_index, result.match_length));
                    end
                end
            end
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    if (paddr[2] == REG_PREFIX_COUNT)
                    begin
                        count_cfg = pwdata[CNT_W-1:0];
                    end
                end
                else if (paddr[2] == REG_PREFIX_COUNT && prdata[CNT_W-1:0] !== count_cfg)
                begin
                    note_error($sformatf("prefix_count read back %0d, expected %0d",
                                         prdata[CNT_W-1:0], count_cfg));
                end
            end
            outstanding <= due_results.size();
        end
    end

endmodule

// ----- test/tb_top.sv -----
`timescale 1ns / 100ps

// Stimulus and verdict for the longest-prefix matcher. The checker beside the block does
// all prediction and comparison; this module only produces command words and register
// accesses, waits on its outstanding count and at the end reads back its failure count.
module tb_top;
    import lpm_pkg::*;

    // Byte addresses on the register port. The second one decodes to no register, so a
    // write there must leave prefix_count alone.
    localparam logic [2:0] ADDR_PREFIX_COUNT = {REG_PREFIX_COUNT, 2'b00};
    localparam logic [2:0] ADDR_UNUSED       = {~REG_PREFIX_COUNT, 2'b00};

    // A finished word passes the compare and both selection states before its result comes
    // out; allow some slack before touching the register once nothing is due any more.
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASES        = 6;
    localparam int PHASE_WORDS   = 290;
    localparam int LONGEST_POS   = 31;

    localparam logic [CHAR_W-1:0] CH_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_B = 8'h62;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    cmd_t        cmd;
    logic        done;
    result_t     result;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int outstanding;
    int results_seen;
    int hits;

    // What the stimulus knows of the table. It is needed to build words that actually
    // match, and to make sure that no slot gains a length over characters that were never
    // loaded, since the block's character memory is not cleared by reset.
    logic [CHAR_W-1:0] shadow_chars   [MAX_PREFIXES][MAX_LEN];
    bit                shadow_written [MAX_PREFIXES][MAX_LEN];
    int                shadow_len     [MAX_PREFIXES];

    int idle_pct;
    int active_slots;
    int words_sent;
    int loads_sent;
    int queries_sent;
    int settings_used;

    longest_prefix_match_unit dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .cmd     (cmd),
        .done    (done),
        .result  (result),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    lpm_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .cmd          (cmd),
        .done         (done),
        .result       (result),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .results_seen (results_seen),
        .hits         (hits)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Safety net: a healthy run finishes in a small fraction of this time.
    initial
    begin
        #500000;
        $display("longest_prefix_match_unit regression: fail");
        $finish;
    end

    function automatic cmd_t mk_cmd(input logic kind, input int slot, input int pos,
                                    input logic [CHAR_W-1:0] ch, input bit last);
        cmd_t c;
        c.kind       = kind;
        c.slot       = slot[SLOT_W-1:0];
        c.char_pos   = pos[POS_W-1:0];
        c.char_value = ch;
        c.last_char  = last;
        return c;
    endfunction

    // Half of all characters come from a two-letter alphabet so that random words still
    // run along the stored prefixes; the byte extremes turn up now and then as well.
    function automatic logic [CHAR_W-1:0] rand_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5)
        begin
            return (r < 3) ? CH_A : CH_B;
        end
        if (r == 5)
        begin
            return $urandom_range(0, 1) ? 8'hff : 8'h00;
        end
        return CHAR_W'($urandom_range(0, 255));
    endfunction

    // Mostly slots that take part in matching, sometimes any slot at all.
    function automatic int pick_slot();
        if (active_slots > 0 && $urandom_range(0, 3) != 0)
        begin
            return $urandom_range(0, active_slots - 1);
        end
        return $urandom_range(0, MAX_PREFIXES - 1);
    endfunction

    // Presents one word and holds it until the block takes it. An idle gap may come first,
    // so that gaps land on every cycle of a query's work.
    task automatic send_word(input cmd_t c);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        forever
        begin
            @(posedge clk);
            if (!busy)
            begin
                break;
            end
        end
        words_sent++;
        if (c.kind == KIND_LOAD)
        begin
            loads_sent++;
            if (c.char_pos < MAX_LEN)
            begin
                shadow_chars[c.slot][c.char_pos]   = c.char_value;
                shadow_written[c.slot][c.char_pos] = 1'b1;
            end
            if (c.last_char)
            begin
                shadow_len[c.slot] = c.char_pos + 1;
            end
        end
        else
        begin
            queries_sent++;
        end
    endtask

    // Loads a whole prefix in position order, so every stored position is written before
    // the slot's length covers it. Most prefixes borrow characters from another slot,
    // which builds nested prefixes and equal-length ties.
    task automatic load_prefix(input int slot, input int len);
        int                donor;
        int                p;
        bit                derive;
        logic [CHAR_W-1:0] c;
        donor  = pick_slot();
        derive = ($urandom_range(0, 9) < 6);
        for (p = 0; p < len; p++)
        begin
            if (derive && p < MAX_LEN && p < shadow_len[donor] && $urandom_range(0, 7) != 0)
            begin
                c = shadow_chars[donor][p];
            end
            else
            begin
                c = rand_char();
            end
            send_word(mk_cmd(KIND_LOAD, slot, p, c, p == len - 1));
        end
    endtask

    // Sends one query. Styles: 0 plain, 1 with skipped positions, 2 ending beyond the
    // stored positions, 3 with a whole prefix load in the middle of the word.
    task automatic query_word(input int style);
        logic [CHAR_W-1:0] w [LONGEST_POS + 1];
        int                base;
        int                plen;
        int                wlen;
        int                p;
        int                tries;
        bit                mid_load_done;
        base          = -1;
        plen          = 0;
        mid_load_done = 1'b0;
        for (tries = 0; tries < 8 && base < 0; tries++)
        begin
            p = pick_slot();
            if (shadow_len[p] > 0)
            begin
                base = p;
            end
        end
        for (p = 0; p <= LONGEST_POS; p++)
        begin
            w[p] = rand_char();
        end
        if (base >= 0)
        begin
            plen = shadow_len[base];
            for (p = 0; p < plen && p < MAX_LEN; p++)
            begin
                w[p] = shadow_chars[base][p];
            end
            if ($urandom_range(0, 9) == 0)
            begin
                wlen = $urandom_range(1, plen);
            end
            else
            begin
                wlen = plen + $urandom_range(0, 3);
            end
        end
        else
        begin
            wlen = $urandom_range(1, 8);
        end
        if (style == 2)
        begin
            wlen = $urandom_range(MAX_LEN + 1, LONGEST_POS + 1);
        end
        if (wlen > LONGEST_POS + 1)
        begin
            wlen = LONGEST_POS + 1;
        end
        // Now and then spoil one stored position so the base prefix falls out.
        if ($urandom_range(0, 6) == 0)
        begin
            p    = $urandom_range(0, ((wlen < MAX_LEN) ? wlen : MAX_LEN) - 1);
            w[p] = ~w[p];
        end
        for (p = 0; p < wlen; p++)
        begin
            if (p == wlen - 1 || style != 1 || $urandom_range(0, 3) != 0)
            begin
                send_word(mk_cmd(KIND_QUERY, $urandom_range(0, MAX_PREFIXES - 1), p, w[p],
                                 p == wlen - 1));
            end
            if (style == 3 && !mid_load_done && p < wlen - 1 && $urandom_range(0, 2) == 0)
            begin
                load_prefix(pick_slot(), $urandom_range(1, 8));
                mid_load_done = 1'b1;
            end
        end
    endtask

    // A single word with every field random. Queries of this kind leave words half done
    // or end them early. A load may only set a length if all positions below it are
    // already loaded; otherwise its last mark is dropped.
    task automatic noise_word();
        cmd_t c;
        int   q;
        c.kind       = 1'($urandom_range(0, 1));
        c.slot       = SLOT_W'($urandom_range(0, MAX_PREFIXES - 1));
        c.char_pos   = POS_W'($urandom_range(0, LONGEST_POS));
        c.char_value = CHAR_W'($urandom_range(0, 255));
        c.last_char  = 1'($urandom_range(0, 1));
        if (c.kind == KIND_LOAD && c.last_char)
        begin
            for (q = 0; q < MAX_LEN && q <= c.char_pos; q++)
            begin
                if (q != c.char_pos && !shadow_written[c.slot][q])
                begin
                    c.last_char = 1'b0;
                end
            end
        end
        send_word(c);
    endtask

    // One register transfer: setup cycle, access cycle, then an idle cycle on the port.
    task automatic apb_xfer(input bit wr, input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Stops sending and waits until every due result has come out. Loads produce no
    // result, so a fixed settling time follows to let any last work drain.
    task automatic quiesce();
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Changes prefix_count while the block is idle and reads it back for the checker.
    task automatic set_count(input int value);
        quiesce();
        apb_xfer(1'b1, ADDR_PREFIX_COUNT, value);
        apb_xfer(1'b0, ADDR_PREFIX_COUNT, '0);
        active_slots = (value > MAX_PREFIXES) ? MAX_PREFIXES : value;
        settings_used++;
    endtask

    initial
    begin : stimulus
        int ph;
        int target;
        int r;
        int plen;
        rst_n   <= 1'b0;
        start   <= 1'b0;
        cmd     <= '0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        idle_pct      = 0;
        active_slots  = 0;
        words_sent    = 0;
        loads_sent    = 0;
        queries_sent  = 0;
        settings_used = 1;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Straight after reset no slot is active, so even a one-letter word finds nothing.
        send_word(mk_cmd(KIND_QUERY, 0, 0, CH_A, 1'b1));

        // Three slots: "a", "ab" and a second "ab" that ties with the first one.
        set_count(3);
        send_word(mk_cmd(KIND_LOAD, 0, 0, CH_A, 1'b1));
        send_word(mk_cmd(KIND_LOAD, 1, 0, CH_A, 1'b0));
        send_word(mk_cmd(KIND_LOAD, 1, 1, CH_B, 1'b1));
        send_word(mk_cmd(KIND_LOAD, 2, 0, CH_A, 1'b0));
        send_word(mk_cmd(KIND_LOAD, 2, 1, CH_B, 1'b1));

        // "ab" takes the longer prefix, and of the tied pair the lower slot.
        send_word(mk_cmd(KIND_QUERY, MAX_PREFIXES - 1, 0, CH_A, 1'b0));
        send_word(mk_cmd(KIND_QUERY, 0, 1, CH_B, 1'b1));
        // "a" is shorter than the two-letter prefixes, which therefore cannot match.
        send_word(mk_cmd(KIND_QUERY, 0, 0, CH_A, 1'b1));
        // "b" matches nothing.
        send_word(mk_cmd(KIND_QUERY, 0, 0, CH_B, 1'b1));
        // A word whose first position is never presented: it is simply not compared.
        send_word(mk_cmd(KIND_QUERY, 0, 1, CH_B, 1'b1));
        // A word ending at the highest position, beyond anything that is stored.
        send_word(mk_cmd(KIND_QUERY, 0, 0, CH_A, 1'b0));
        send_word(mk_cmd(KIND_QUERY, 0, LONGEST_POS, 8'hff, 1'b1));

        // A character beyond the stored positions is dropped; then slot 3 becomes a
        // one-byte prefix of value zero, outside the active range for now.
        send_word(mk_cmd(KIND_LOAD, 3, MAX_LEN + 5, 8'hff, 1'b0));
        send_word(mk_cmd(KIND_LOAD, 3, 0, 8'h00, 1'b1));
        send_word(mk_cmd(KIND_QUERY, MAX_PREFIXES - 1, 0, 8'h00, 1'b1));

        // A count above the table size acts as the whole table, so slot 3 now answers.
        set_count(255);
        send_word(mk_cmd(KIND_QUERY, 0, 0, 8'h00, 1'b1));

        // A write to an address with no register behind it must change nothing.
        quiesce();
        apb_xfer(1'b1, ADDR_UNUSED, 32'h0000_0000);
        send_word(mk_cmd(KIND_QUERY, 0, 0, 8'h00, 1'b1));

        // Random phases, each with its own prefix_count and idling pattern.
        for (ph = 0; ph < PHASES; ph++)
        begin
            case (ph)
                0:       begin idle_pct = 0;  set_count(MAX_PREFIXES);             end
                1:       begin idle_pct = 66; set_count($urandom_range(2, 127));   end
                2:       begin idle_pct = 15; set_count(255);                      end
                3:       begin idle_pct = 0;  set_count(1);                        end
                4:       begin idle_pct = 66; set_count(MAX_PREFIXES);             end
                default: begin idle_pct = 15; set_count($urandom_range(0, 255));   end
            endcase
            target = words_sent + PHASE_WORDS;
            while (words_sent < target)
            begin
                r = $urandom_range(0, 99);
                if (r < 30)
                begin
                    // Mostly short prefixes, some longer up to full length, a few past the stored range.
                    r = $urandom_range(0, 99);
                    if (r < 80)
                    begin
                        plen = $urandom_range(1, 8);
                    end
                    else if (r < 95)
                    begin
                        plen = $urandom_range(9, MAX_LEN);
                    end
                    else
                    begin
                        plen = $urandom_range(MAX_LEN + 1, LONGEST_POS + 1);
                    end
                    load_prefix(pick_slot(), plen);
                end
                else if (r < 70)
                begin
                    query_word(0);
                end
                else if (r < 78)
                begin
                    query_word(1);
                end
                else if (r < 83)
                begin
                    query_word(2);
                end
                else if (r < 90)
                begin
                    query_word(3);
                end
                else
                begin
                    noise_word();
                end
            end
        end

        quiesce();
        $display("Drove %0d command words (%0d loads, %0d queries) under %0d prefix_count values.",
                 words_sent, loads_sent, queries_sent, settings_used);
        $display("Compared %0d match results, %0d of which reported a hit.",
                 results_seen, hits);
        if (fail_count == 0 && outstanding == 0)
        begin
            $display("longest_prefix_match_unit regression: pass");
        end
        else
        begin
            $display("longest_prefix_match_unit regression: fail");
        end
        $finish;
    end

endmodule
